### rtl/pcev_pkg.sv
// Package for the piecewise linear curve evaluator.
// Holds the field widths, table sizing, request type and state encoding.
// Depends on nothing; every other file but pcev_ram imports it.
package pcev_pkg;

    // Table sizing
    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths fixed by the interface
    localparam int PIDX_W = 4;
    localparam int POS_W  = 16;
    localparam int VAL_W  = 16;
    localparam int CFG_W  = 5;

    // Table entry: x in the upper half, y in the lower half
    localparam int ENTRY_W = POS_W + VAL_W;

    // Serial divider produces one quotient bit a cycle
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Classified request: pos is the point x for a write, t for an evaluation
    typedef struct packed {
        logic                    is_eval;
        logic [PIDX_W-1:0]       idx;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_stat;

    // Back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_RESULT
    } t_back_state;

endpackage

### rtl/piecewise_linear_curve_eval_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_operation, i_point_index, i_point_pos,
//                                                 i_point_value, i_position
// output    out        o_out_valid / i_out_stall  o_curve_value, o_is_evaluation
// config    in         i_cfg_we                   i_cfg_data (points in use)
//
// A write request in the back end goes from ST_IDLE to ST_RESULT once at the queue head.
// An evaluation that stops at point k of the table scans the entries up to k, with
// one table read a cycle during the scan, and then returns an end point or
// interpolates with a bit-serial divider and one multiply.
// Synchronous active-low reset empties the queue and output; the table holds
// no reset and points in use returns to one. A stalled output leaves the
// request queue (two entries plus the front holding register) to keep filling.
//
// Top level of the piecewise linear curve evaluator.
// Depends on pcev_pkg, pcev_front, pcev_queue and pcev_back.
module piecewise_linear_curve_eval_top
    import pcev_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_operation,
    input  logic [PIDX_W-1:0]       i_point_index,
    input  logic [POS_W-1:0]        i_point_pos,
    input  logic signed [VAL_W-1:0] i_point_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_curve_value,
    output logic                    o_is_evaluation
);

    logic        q_push;
    logic        q_pop;
    t_cmd        q_in;
    t_cmd        q_head;
    t_queue_stat q_stat;

    // Front end: accept and classify requests
    pcev_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_point_index (i_point_index),
        .i_point_pos   (i_point_pos),
        .i_point_value (i_point_value),
        .i_position    (i_position),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    // Request queue
    pcev_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Back end: table, scan, divide, interpolate
    pcev_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_head          (q_head),
        .i_q_stat        (q_stat),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_curve_value   (o_curve_value),
        .o_is_evaluation (o_is_evaluation)
    );

`ifndef SYNTHESIS
    // A write acknowledge always carries a zero value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_evaluation) |-> (o_curve_value == '0))
        else $error("write acknowledge with non-zero value");

    // The back end only takes a request when the queue holds one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("pop from empty request queue");

    // The front end only pushes when the queue has room.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full request queue");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");
`endif

endmodule

### rtl/pcev_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Used for the curve point table; no package dependency.
module pcev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pcev_front.sv
// Front end: takes input requests, classifies them and hands them to the queue.
// Depends on pcev_pkg for the request type.
module pcev_front
    import pcev_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_operation,
    input  logic [PIDX_W-1:0]       i_point_index,
    input  logic [POS_W-1:0]        i_point_pos,
    input  logic signed [VAL_W-1:0] i_point_value,
    input  logic [POS_W-1:0]        i_position,
    input  t_queue_stat             i_q_stat,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    logic r_req_valid;
    t_cmd r_req;
    t_cmd cls_cmd;
    logic accept;

    // Classify: an evaluation carries t in the position slot, a write its x
    always_comb begin
        cls_cmd.is_eval = (i_operation == OP_EVAL);
        cls_cmd.idx     = i_point_index;
        cls_cmd.pos     = (i_operation == OP_EVAL) ? i_position : i_point_pos;
        cls_cmd.value   = i_point_value;
    end

    // The holding register is stalled only while the queue is full
    assign o_in_stall = r_req_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_req_valid && !i_q_stat.full;
    assign o_cmd      = r_req;

    // Holding register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= accept || (r_req_valid && i_q_stat.full);
        end
    end

    // Holding register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= cls_cmd;
        end
    end

endmodule

### rtl/pcev_queue.sv
// Short request queue between the front end and the back end.
// Depends on pcev_pkg for the request type and the queue depth.
module pcev_queue
    import pcev_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cmd        i_cmd,
    input  logic        i_pop,
    output t_cmd        o_head,
    output t_queue_stat o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign do_push          = i_push && !o_stat.full;
    assign do_pop           = i_pop && o_stat.not_empty;
    assign o_head           = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/pcev_back.sv
// Back end: owns the point table, scans it, divides serially and interpolates.
// Depends on pcev_pkg and instantiates pcev_ram for the table.
module pcev_back
    import pcev_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  t_cmd                    i_head,
    input  t_queue_stat             i_q_stat,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_curve_value,
    output logic                    o_is_evaluation
);

    t_back_state r_state, n_state;

    // Configuration and scan registers
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_rd_idx;
    logic                    r_chk_valid;
    logic [ADDR_W-1:0]       r_chk_idx;
    logic [POS_W-1:0]        r_t;
    logic [POS_W-1:0]        r_prev_x;
    logic signed [VAL_W-1:0] r_prev_y;

    // Divider and multiplier registers
    logic [POS_W-1:0]        r_span;
    logic [POS_W-1:0]        r_rem;
    logic [POS_W-1:0]        r_quo;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic signed [VAL_W:0]   r_diff;
    logic signed [2*VAL_W+1:0] r_prod;

    // Result and output registers
    logic signed [VAL_W-1:0] r_res;
    logic                    r_res_eval;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_eval;

    // Table port signals
    logic                    wr_en;
    logic                    rd_en;
    logic [ENTRY_W-1:0]      rd_data;
    logic [POS_W-1:0]        rx;
    logic signed [VAL_W-1:0] ry;
    logic [ADDR_W-1:0]       last_idx;
    logic [CNT_W-1:0]        cfg_clamped;

    // Scan decisions and arithmetic helpers
    logic                    at_first;
    logic                    do_interp;
    logic                    at_last;
    logic [POS_W:0]          trial;
    logic                    trial_ge;
    logic [VAL_W+1:0]        fin_sum;
    logic                    out_free;
    logic                    load_out;

    pcev_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_head.idx)),
        .i_wdata ({i_head.pos, i_head.value}),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rx       = rd_data[ENTRY_W-1:VAL_W];
    assign ry       = rd_data[VAL_W-1:0];
    assign last_idx = ADDR_W'(r_n - 1'b1);

    // Zero points behaves as one, more than the table holds saturates
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (32'(i_cfg_data) > MAX_POINTS) begin
            cfg_clamped = CNT_W'(MAX_POINTS);
        end else begin
            cfg_clamped = CNT_W'(i_cfg_data);
        end
    end

    // Segment decisions on the entry that has just been read
    assign at_first  = (r_chk_idx == '0) && (rx >= r_t);
    assign do_interp = (r_chk_idx != '0) && (rx > r_t);
    assign at_last   = (r_chk_idx == last_idx);

    // One restoring division step: the remainder stays below the span
    assign trial    = {r_rem, 1'b0};
    assign trial_ge = (trial >= {1'b0, r_span});

    // Final add: ya plus the arithmetically shifted product
    assign fin_sum = {{2{r_prev_y[VAL_W-1]}}, r_prev_y} + r_prod[2*VAL_W+1:VAL_W];

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and control
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_stat.not_empty) begin
                    o_pop = 1'b1;
                    if (i_head.is_eval) begin
                        n_state = ST_SCAN;
                    end else begin
                        wr_en   = (32'(i_head.idx) < MAX_POINTS);
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = (r_rd_idx < r_n);
                if (r_chk_valid) begin
                    if (at_first) begin
                        n_state = ST_RESULT;
                    end else if (do_interp) begin
                        n_state = ST_DIV;
                    end else if (at_last) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Points in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_n <= cfg_clamped;
        end
    end

    // Scan, divide and multiply datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_t         <= i_head.pos;
                r_rd_idx    <= '0;
                r_chk_valid <= 1'b0;
                r_res       <= '0;
                r_res_eval  <= i_head.is_eval;
            end
            ST_SCAN: begin
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                r_chk_valid <= rd_en;
                r_chk_idx   <= r_rd_idx[ADDR_W-1:0];
                if (r_chk_valid) begin
                    if (at_first) begin
                        r_res <= ry;
                    end else if (do_interp) begin
                        r_span <= rx - r_prev_x;
                        r_rem  <= r_t - r_prev_x;
                        r_diff <= {ry[VAL_W-1], ry} - {r_prev_y[VAL_W-1], r_prev_y};
                        r_cnt  <= '0;
                    end else begin
                        r_prev_x <= rx;
                        r_prev_y <= ry;
                        r_res    <= ry;
                    end
                end
            end
            ST_DIV: begin
                r_rem <= trial_ge ? POS_W'(trial - {1'b0, r_span}) : trial[POS_W-1:0];
                r_quo <= {r_quo[POS_W-2:0], trial_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_MUL: begin
                r_prod <= r_diff * $signed({1'b0, r_quo});
            end
            ST_FIN: begin
                r_res <= fin_sum[VAL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= r_res;
            r_out_eval  <= r_res_eval;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_curve_value   = r_out_value;
    assign o_is_evaluation = r_out_eval;

endmodule
